>>> rtl/core/crcpc_pkg.sv
// crcpc_pkg: types, constants and the CRC-32C byte update for the page checksum block.
// No dependencies; imported by crc32c_page_checksum and crcpc_checker.
package crcpc_pkg;

  localparam logic [31:0] CrcInit      = 32'hffff_ffff;
  localparam logic [16:0] PageMax      = 17'd65536;
  localparam logic [16:0] PageSizeRst  = 17'd4096;
  localparam int          CfgIdxW      = 2;
  localparam int          CfgDataW     = 17;

  localparam logic [CfgIdxW-1:0] RegPageMode   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPageSize   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegChkOffset  = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_beat_t;

  typedef struct packed {
    logic [31:0] crc_value;
    logic [31:0] stored_checksum;
    logic        checksum_match;
    logic        bad_config;
  } result_beat_t;

  // reflected CRC-32C, 0x82f63b78, one nibble per table lookup
  function automatic logic [31:0] nib_lookup(input logic [3:0] n);
    logic [31:0] v;
    case (n)
      4'h0:    v = 32'h0000_0000;
      4'h1:    v = 32'h105e_c76f;
      4'h2:    v = 32'h20bd_8ede;
      4'h3:    v = 32'h30e3_49b1;
      4'h4:    v = 32'h417b_1dbc;
      4'h5:    v = 32'h5125_dad3;
      4'h6:    v = 32'h61c6_9362;
      4'h7:    v = 32'h7198_540d;
      4'h8:    v = 32'h82f6_3b78;
      4'h9:    v = 32'h92a8_fc17;
      4'ha:    v = 32'ha24b_b5a6;
      4'hb:    v = 32'hb215_72c9;
      4'hc:    v = 32'hc38d_26c4;
      4'hd:    v = 32'hd3d3_e1ab;
      4'he:    v = 32'he330_a81a;
      4'hf:    v = 32'hf36e_6f75;
      default: v = 32'h0000_0000;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] t;
    t = c ^ {24'd0, b};
    t = (t >> 4) ^ nib_lookup(t[3:0]);
    t = (t >> 4) ^ nib_lookup(t[3:0]);
    return t;
  endfunction

endpackage

>>> rtl/core/crc32c_page_checksum.sv
// crc32c_page_checksum: streaming CRC-32C over bytes, plain messages or fixed-size pages.
// Depends on crcpc_pkg (beat types, CRC byte update, register indexes).
//
//   channel  direction  handshake                 payload
//   byte     in         byte_valid / byte_stall   byte_beat_t
//   result   out        result_valid / result_stall  result_beat_t
//   cfg      in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One byte per cycle while byte_stall is low; the result beat is registered. The
// path is the two nibble-table steps of the CRC update plus the final compare.
// Reset (rst, synchronous) restores the registers and the running CRC.
// byte_stall rises only while a result is held and result_stall is high.
// Any cfg write abandons the message or page in progress.
module crc32c_page_checksum (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           byte_valid,
  output logic                           byte_stall,
  input  crcpc_pkg::byte_beat_t          byte_beat,
  output logic                           result_valid,
  input  logic                           result_stall,
  output crcpc_pkg::result_beat_t        result_beat,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [crcpc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [crcpc_pkg::CfgDataW-1:0] cfg_data
);
  import crcpc_pkg::*;

  logic        page_mode;
  logic [16:0] page_len;
  logic [15:0] checksum_offset;
  logic [31:0] running_crc;
  logic [15:0] byte_position;
  logic [31:0] captured_checksum;

  logic [31:0] running_crc_next;
  logic [15:0] byte_position_next;
  logic [31:0] captured_checksum_next;
  logic        emit;
  result_beat_t result_next;

  logic        take;
  logic [16:0] eff_size;
  logic [16:0] pos_diff;
  logic        in_field;
  logic [16:0] pos_inc;
  logic        bad;
  logic [31:0] crc_plain;
  logic [31:0] crc_page;
  logic [31:0] crc_out;

  assign cfg_ready  = 1'b1;
  assign byte_stall = result_valid & result_stall;
  assign take       = byte_valid & ~byte_stall;

  always_comb begin
    if (page_len == 17'd0) begin
      eff_size = 17'd1;
    end else if (page_len > PageMax) begin
      eff_size = PageMax;
    end else begin
      eff_size = page_len;
    end
  end

  assign pos_diff  = {1'b0, byte_position} - {1'b0, checksum_offset};
  assign in_field  = (byte_position >= checksum_offset) && (pos_diff < 17'd4);
  assign pos_inc   = {1'b0, byte_position} + 17'd1;
  assign bad       = ({1'b0, checksum_offset} + 17'd4) > eff_size;
  assign crc_plain = crc_byte(running_crc, byte_beat.data_byte);
  assign crc_page  = crc_byte(running_crc, in_field ? 8'd0 : byte_beat.data_byte);

  always_comb begin
    running_crc_next       = running_crc;
    byte_position_next     = byte_position;
    captured_checksum_next = captured_checksum;
    emit                   = 1'b0;
    crc_out                = '0;
    result_next            = '0;
    if (!page_mode) begin
      running_crc_next = crc_plain;
      crc_out          = crc_plain ^ CrcInit;
      if (byte_beat.last_byte) begin
        emit                       = 1'b1;
        result_next.crc_value      = crc_out;
        running_crc_next           = CrcInit;
        byte_position_next         = '0;
        captured_checksum_next     = '0;
      end
    end else begin
      running_crc_next = crc_page;
      if (in_field) begin
        case (pos_diff[1:0])
          2'd0:    captured_checksum_next[7:0]   = byte_beat.data_byte;
          2'd1:    captured_checksum_next[15:8]  = byte_beat.data_byte;
          2'd2:    captured_checksum_next[23:16] = byte_beat.data_byte;
          2'd3:    captured_checksum_next[31:24] = byte_beat.data_byte;
          default: captured_checksum_next        = captured_checksum;
        endcase
      end
      crc_out = crc_page ^ CrcInit;
      if (pos_inc < eff_size) begin
        byte_position_next = pos_inc[15:0];
      end else begin
        emit                        = 1'b1;
        result_next.crc_value       = crc_out;
        result_next.stored_checksum = captured_checksum_next;
        result_next.checksum_match  = ~bad && (captured_checksum_next == crc_out);
        result_next.bad_config      = bad;
        running_crc_next            = CrcInit;
        byte_position_next          = '0;
        captured_checksum_next      = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page_mode         <= 1'b0;
      page_len          <= PageSizeRst;
      checksum_offset   <= '0;
      running_crc       <= CrcInit;
      byte_position     <= '0;
      captured_checksum <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        RegPageMode:  page_mode       <= cfg_data[0];
        RegPageSize:  page_len        <= cfg_data[16:0];
        RegChkOffset: checksum_offset <= cfg_data[15:0];
        default:      ;
      endcase
      running_crc       <= CrcInit;
      byte_position     <= '0;
      captured_checksum <= '0;
    end else if (take) begin
      running_crc       <= running_crc_next;
      byte_position     <= byte_position_next;
      captured_checksum <= captured_checksum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take && emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      result_beat <= result_next;
    end
  end

endmodule

>>> rtl/core/crcpc_checker.sv
// crcpc_checker: port-level assertions for crc32c_page_checksum, bound to the top level.
// Depends on crcpc_pkg for the beat types.
module crcpc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           byte_stall,
  input logic                           result_valid,
  input logic                           result_stall,
  input crcpc_pkg::result_beat_t        result_beat
);
  import crcpc_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result beat dropped while stalled");

  a_hold_beat: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(result_beat))
    else $error("stalled result beat changed");

  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  a_match_sane: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_beat.checksum_match |->
      !result_beat.bad_config && (result_beat.crc_value == result_beat.stored_checksum))
    else $error("checksum_match inconsistent with fields");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> result_valid && result_stall)
    else $error("byte channel stalled without a held result");

endmodule

bind crc32c_page_checksum crcpc_checker u_crcpc_checker (.*);
